>>> rtl/carv_pkg.sv
// constants, register codes and fixed-point helpers for the comb/allpass reverb
package carv_pkg;

  localparam int COMB_DEPTH      = 2048;
  localparam int ALLPASS_DEPTH   = 1024;
  localparam int ALLPASS_DELAY_A = 556;
  localparam int ALLPASS_DELAY_B = 441;
  localparam int NUM_COMBS       = 4;
  localparam int COMB_AW         = $clog2(COMB_DEPTH);
  localparam int AP_AW           = $clog2(ALLPASS_DEPTH);

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALLPASS  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WET      = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRY      = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_A  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_B  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_C  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_D  = 4'd7;

  localparam logic [14:0] FB_LIMIT      = 15'd32112;
  localparam logic [14:0] RST_FEEDBACK  = 15'd22938;
  localparam logic [14:0] RST_ALLPASS   = 15'd16384;
  localparam logic [14:0] RST_WET       = 15'd16384;
  localparam logic [14:0] RST_DRY       = 15'd16384;
  localparam logic [10:0] RST_DELAY_A   = 11'd1116;
  localparam logic [10:0] RST_DELAY_B   = 11'd1188;
  localparam logic [10:0] RST_DELAY_C   = 11'd1277;
  localparam logic [10:0] RST_DELAY_D   = 11'd1356;

  typedef logic signed [23:0] word_t;
  typedef logic signed [39:0] prod_t;

  // floor((p + 2^14) / 2^15)
  function automatic logic signed [25:0] round15(input logic signed [40:0] p);
    logic signed [40:0] t;
    t = (p + 41'sd16384) >>> 15;
    return t[25:0];
  endfunction

  function automatic word_t sat24(input logic signed [25:0] v);
    if (v > 26'sd8388607) begin
      return 24'sh7fffff;
    end else if (v < -26'sd8388608) begin
      return 24'sh800000;
    end
    return v[23:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [25:0] v);
    if (v > 26'sd32767) begin
      return 16'sh7fff;
    end else if (v < -26'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

endpackage

>>> rtl/comb_allpass_reverb_core.sv
// schroeder reverb core: four comb lines and two allpass stages in two memories
// Each accepted sample is handled by a transfer and a 14-step sequence
// that runs the comb and allpass reads, writes and gain products through a single
// 16x24 multiplier, the allpass chain being strictly dependent from one product to
// the next; the next sample is taken in the cycle after the result is registered,
// even while that result still waits on the output. After reset a clearing pass
// zeroes every delay memory word; no sample is accepted during that pass, and
// configuration writes are taken at all times.
module comb_allpass_reverb_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [15:0]                  sample_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [15:0]                  sample_out,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [carv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [carv_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CA = carv_pkg::COMB_AW;
  localparam int AA = carv_pkg::AP_AW;
  localparam int CM_AW = CA + 2;
  localparam int AM_AW = AA + 1;
  localparam int CLR_COUNT = (4 * carv_pkg::COMB_DEPTH > 2 * carv_pkg::ALLPASS_DEPTH) ?
                             4 * carv_pkg::COMB_DEPTH : 2 * carv_pkg::ALLPASS_DEPTH;
  localparam int CLR_W = $clog2(CLR_COUNT);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;

  localparam logic [3:0] STEP_LAST = 4'd13;

  // configuration
  logic [14:0] fb_gain, ap_gain, wet_gain, dry_gain;
  logic [10:0] cdly [0:3];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fb_gain  <= carv_pkg::RST_FEEDBACK;
      ap_gain  <= carv_pkg::RST_ALLPASS;
      wet_gain <= carv_pkg::RST_WET;
      dry_gain <= carv_pkg::RST_DRY;
      cdly[0]  <= carv_pkg::RST_DELAY_A;
      cdly[1]  <= carv_pkg::RST_DELAY_B;
      cdly[2]  <= carv_pkg::RST_DELAY_C;
      cdly[3]  <= carv_pkg::RST_DELAY_D;
    end else if (cfg_valid) begin
      case (cfg_index)
        carv_pkg::REG_FEEDBACK: begin
          // clamp at 0.98 once, on the write
          fb_gain <= (cfg_data[14:0] > carv_pkg::FB_LIMIT) ? carv_pkg::FB_LIMIT
                                                           : cfg_data[14:0];
        end
        carv_pkg::REG_ALLPASS: ap_gain  <= cfg_data[14:0];
        carv_pkg::REG_WET:     wet_gain <= cfg_data[14:0];
        carv_pkg::REG_DRY:     dry_gain <= cfg_data[14:0];
        carv_pkg::REG_DELAY_A: cdly[0]  <= cfg_data[10:0];
        carv_pkg::REG_DELAY_B: cdly[1]  <= cfg_data[10:0];
        carv_pkg::REG_DELAY_C: cdly[2]  <= cfg_data[10:0];
        carv_pkg::REG_DELAY_D: cdly[3]  <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // control
  logic [1:0]       state;
  logic [3:0]       step;
  logic [CLR_W-1:0] clr_cnt;
  logic [CA-1:0]    comb_w;
  logic [AA-1:0]    ap_w;
  logic             fin;

  assign in_ready = (state == ST_IDLE);
  assign fin = (state == ST_RUN) && (step == STEP_LAST) && (!out_valid || out_ready);

  // datapath registers
  logic signed [15:0] x;
  logic signed [25:0] sum;
  carv_pkg::word_t    sig, bi, bo0, bo1, comb_rd, ap_rd;
  carv_pkg::prod_t    prod, pbo1, acc;

  // memories
  carv_pkg::word_t comb_mem [0:4*carv_pkg::COMB_DEPTH-1];
  carv_pkg::word_t ap_mem   [0:2*carv_pkg::ALLPASS_DEPTH-1];

  logic            comb_we, ap_we;
  logic [CM_AW-1:0] comb_raddr, comb_waddr;
  logic [AM_AW-1:0] ap_raddr, ap_waddr;
  carv_pkg::word_t comb_wdata, ap_wdata;

  logic [1:0]      rline, wline;
  logic [14:0]     mul_g;
  carv_pkg::word_t mul_v;
  logic signed [25:0] rnd_prod, rnd_pbo1, rnd_mix;
  logic signed [15:0] y;

  assign rline = step[1:0];
  assign wline = 2'(step - 4'd2);
  assign rnd_prod = carv_pkg::round15({prod[39], prod});
  assign rnd_pbo1 = carv_pkg::round15({pbo1[39], pbo1});
  assign rnd_mix  = carv_pkg::round15({acc[39], acc} + {prod[39], prod});
  assign y = carv_pkg::sat16(rnd_mix);

  always_comb begin
    comb_raddr = {rline, 2'b00} == 4'd0 ? {rline, comb_w - CA'(cdly[0])}
                                        : {rline, comb_w - CA'(cdly[rline])};
    ap_raddr   = (step == 4'd0) ? {1'b0, ap_w - AA'(carv_pkg::ALLPASS_DELAY_A)}
                                : {1'b1, ap_w - AA'(carv_pkg::ALLPASS_DELAY_B)};
    comb_we    = 1'b0;
    comb_waddr = {wline, comb_w};
    comb_wdata = carv_pkg::sat24({{10{x[15]}}, x} + rnd_prod);
    ap_we      = 1'b0;
    ap_waddr   = {1'b0, ap_w};
    ap_wdata   = carv_pkg::sat24({{2{sig[23]}}, sig} + rnd_prod);
    if (state == ST_CLEAR) begin
      comb_we    = 1'b1;
      comb_waddr = CM_AW'(clr_cnt);
      comb_wdata = '0;
      ap_we      = 1'b1;
      ap_waddr   = AM_AW'(clr_cnt);
      ap_wdata   = '0;
    end else if (state == ST_RUN) begin
      if (step inside {[4'd2:4'd5]}) begin
        comb_we = 1'b1;
      end
      if (step == 4'd6) begin
        ap_we = 1'b1;
      end else if (step == 4'd9) begin
        ap_we    = 1'b1;
        ap_waddr = {1'b1, ap_w};
        ap_wdata = carv_pkg::sat24({{2{sig[23]}}, sig} + rnd_pbo1);
      end
    end
  end

  // each line is read before this item writes it, and items do not overlap
  always_ff @(posedge clk) begin
    if (comb_we) begin
      comb_mem[comb_waddr] <= comb_wdata;
    end
    comb_rd <= comb_mem[comb_raddr];
  end

  always_ff @(posedge clk) begin
    if (ap_we) begin
      ap_mem[ap_waddr] <= ap_wdata;
    end
    ap_rd <= ap_mem[ap_raddr];
  end

  // shared multiplier operands
  always_comb begin
    case (step)
      4'd5:    begin mul_g = ap_gain;  mul_v = bo0; end
      4'd6:    begin mul_g = ap_gain;  mul_v = bo1; end
      4'd7:    begin mul_g = ap_gain;  mul_v = bi;  end
      4'd8:    begin mul_g = dry_gain; mul_v = {{8{x[15]}}, x}; end
      4'd10:   begin mul_g = ap_gain;  mul_v = bi;  end
      4'd12:   begin mul_g = wet_gain; mul_v = sig; end
      default: begin mul_g = fb_gain;  mul_v = comb_rd; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_RUN && step != STEP_LAST) begin
      prod <= $signed({1'b0, mul_g}) * mul_v;
    end
    if (in_valid && in_ready) begin
      x   <= sample_in;
      sum <= '0;
    end
    if (state == ST_RUN) begin
      case (step)
        4'd1: bo0 <= ap_rd;
        4'd2: bo1 <= ap_rd;
        4'd5: begin
          sig <= carv_pkg::word_t'((sum + 26'sd2) >>> 2);
        end
        4'd6: bi <= carv_pkg::sat24({{2{sig[23]}}, sig} + rnd_prod);
        4'd7: pbo1 <= prod;
        4'd8: sig <= carv_pkg::sat24({{2{bo0[23]}}, bo0} - rnd_prod);
        4'd9: begin
          acc <= prod;
          bi  <= carv_pkg::sat24({{2{sig[23]}}, sig} + rnd_pbo1);
        end
        4'd11: sig <= carv_pkg::sat24({{2{bo1[23]}}, bo1} - rnd_prod);
        default: ;
      endcase
      if (step inside {[4'd1:4'd4]}) begin
        sum <= sum + {{2{comb_rd[23]}}, comb_rd};
      end
    end
    if (fin) begin
      sample_out <= y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      step      <= '0;
      clr_cnt   <= '0;
      comb_w    <= '0;
      ap_w      <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == CLR_W'(CLR_COUNT - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_RUN;
            step  <= '0;
          end
        end
        ST_RUN: begin
          if (step != STEP_LAST) begin
            step <= step + 4'd1;
          end else if (fin) begin
            state  <= ST_IDLE;
            comb_w <= comb_w + 1'b1;
            ap_w   <= ap_w + 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (fin) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // checks
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !comb_we && !ap_we)
    else $error("delay memory written while idle");

  a_fin_valid: assert property (@(posedge clk) disable iff (rst)
    fin |=> out_valid)
    else $error("finished sample not presented");

  a_index_step: assert property (@(posedge clk) disable iff (rst)
    fin |=> comb_w == CA'($past(comb_w) + 1'b1) && ap_w == AA'($past(ap_w) + 1'b1))
    else $error("write index did not advance by one");

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !in_ready && comb_we)
    else $error("sample taken during clearing pass");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !fin)
    else $error("pending result overwritten");

endmodule
